@@ sv/rada_pkg.sv @@
// Shared constants, codes and types for the ratiometric ADC averager.
package rada_pkg;

    localparam int ADC_BITS_DEF    = 12;
    localparam int MAX_SAMPLES_DEF = 32;

    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOADED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OUTPUT = 2'd2;

    localparam logic [1:0] REG_DISCARD   = 2'd0;
    localparam logic [1:0] REG_SAMPLES   = 2'd1;
    localparam logic [1:0] REG_REFERENCE = 2'd2;
    localparam logic [1:0] REG_SCALE     = 2'd3;

    localparam logic [3:0] DISCARD_RST   = 4'd4;
    localparam logic [5:0] SAMPLES_RST   = 6'd18;
    localparam logic [7:0] REFERENCE_RST = 8'd120;
    localparam logic [7:0] SCALE_RST     = 8'd144;

    localparam logic [VALUE_W-1:0] VALUE_SAT = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              chan;
    } job_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHECK,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

@@ sv/rada_fifo.sv @@
// Two-entry job queue between the window accumulator and the divider.
module rada_fifo
    import rada_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !empty)
        else $error("queue empty after push");

endmodule

@@ sv/rada_front.sv @@
// Window accumulator: skips, sums, tracks phase and load, issues divide jobs.
module rada_front
    import rada_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 16),
    localparam int SUM_W = ADC_BITS + CNT_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                load_on,
    input  logic [3:0]          discard_cfg,
    input  logic [5:0]          samples_cfg,
    input  logic [7:0]          reference_cfg,
    input  logic [7:0]          scale_cfg,
    output logic                push,
    output job_ctl_t            job_ctl,
    output logic [SUM_W-1:0]    job_op_a,
    output logic [7:0]          job_op_b,
    output logic [SUM_W-1:0]    job_den
);

    localparam int SMP_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] bandgap_reg, bandgap_next;
    logic             phase_reg, phase_next;
    logic             load_prev_reg, load_prev_next;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] cnt_inc;
    logic [SUM_W-1:0] sum_add;
    logic             win_done;

    always_comb begin
        if (samples_cfg == 6'd0) begin
            n_eff = CNT_W'(1);
        end else if (int'(samples_cfg) > MAX_SAMPLES) begin
            n_eff = CNT_W'(MAX_SAMPLES);
        end else begin
            n_eff = CNT_W'(samples_cfg);
        end
    end

    assign limit    = CNT_W'(discard_cfg) + n_eff;
    assign cnt_inc  = count_reg + CNT_W'(1);
    assign sum_add  = (count_reg >= CNT_W'(discard_cfg))
                    ? sum_reg + SUM_W'(sample[SMP_W-1:0]) : sum_reg;
    assign win_done = (cnt_inc >= limit);

    always_comb begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        bandgap_next   = bandgap_reg;
        phase_next     = phase_reg;
        load_prev_next = load_prev_reg;
        push           = 1'b0;
        job_ctl.kind   = KIND_OUTPUT;
        job_ctl.chan   = 1'b0;
        job_op_a       = sum_add;
        job_op_b       = scale_cfg;
        job_den        = bandgap_reg;
        if (!phase_reg) begin
            job_ctl.kind = load_prev_reg ? KIND_LOADED : KIND_IDLE;
            job_ctl.chan = load_prev_reg;
            job_op_a     = SUM_W'(n_eff);
            job_op_b     = reference_cfg;
            job_den      = sum_add;
        end
        if (accept) begin
            if (load_on != load_prev_reg) begin
                load_prev_next = load_on;
                count_next     = '0;
                sum_next       = '0;
                phase_next     = 1'b0;
            end else if (!win_done) begin
                count_next = cnt_inc;
                sum_next   = sum_add;
            end else begin
                push       = 1'b1;
                count_next = '0;
                sum_next   = '0;
                phase_next = job_ctl.chan;
                if (!phase_reg) begin
                    bandgap_next = sum_add;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sum_reg       <= '0;
            bandgap_reg   <= '0;
            phase_reg     <= 1'b0;
            load_prev_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            bandgap_reg   <= bandgap_next;
            phase_reg     <= phase_next;
            load_prev_reg <= load_prev_next;
        end
    end

endmodule

@@ sv/rada_back.sv @@
// Divide engine: one multiply, saturation check, 16-step restoring divide.
module rada_back
    import rada_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 16),
    localparam int SUM_W = ADC_BITS + CNT_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    input  job_ctl_t           job_ctl,
    input  logic [SUM_W-1:0]   job_op_a,
    input  logic [7:0]         job_op_b,
    input  logic [SUM_W-1:0]   job_den,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  out_kind,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_chan
);

    localparam int NUM_W = SUM_W + 8;
    localparam int DSH_W = SUM_W + VALUE_W;
    localparam int STEP_W = $clog2(VALUE_W);

    back_state_t        state_reg, state_next;
    job_ctl_t           ctl_reg;
    logic [SUM_W-1:0]   op_a_reg;
    logic [7:0]         op_b_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DSH_W-1:0]   rem_reg;
    logic [DSH_W-1:0]   dsh_reg;
    logic [VALUE_W-1:0] quo_reg;
    logic               sat_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_chan_reg;

    logic [NUM_W-1:0]   prod;
    logic               out_free;
    logic               out_load;
    logic               rem_ge;

    assign prod     = NUM_W'(op_a_reg) * NUM_W'(op_b_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign rem_ge   = (rem_reg >= dsh_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (job_valid) state_next = BK_MUL;
            BK_MUL:   state_next = BK_CHECK;
            BK_CHECK: state_next = BK_DIV;
            BK_DIV:   if (step_reg == '0) state_next = BK_DONE;
            BK_DONE:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = (state_reg == BK_IDLE) && job_valid;
        out_load = (state_reg == BK_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ctl_reg  <= job_ctl;
            op_a_reg <= job_op_a;
            op_b_reg <= job_op_b;
            den_reg  <= job_den;
        end
        if (state_reg == BK_MUL) begin
            num_reg <= (ctl_reg.kind == KIND_OUTPUT) ? prod : (prod << ADC_BITS);
        end
        if (state_reg == BK_CHECK) begin
            sat_reg  <= (den_reg == '0) || (DSH_W'(num_reg) >= {den_reg, VALUE_W'(0)});
            rem_reg  <= DSH_W'(num_reg);
            dsh_reg  <= DSH_W'({den_reg, VALUE_W'(0)} >> 1);
            quo_reg  <= '0;
            step_reg <= STEP_W'(VALUE_W - 1);
        end
        if (state_reg == BK_DIV) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg  <= {quo_reg[VALUE_W-2:0], rem_ge};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (out_load) begin
            out_kind_reg  <= ctl_reg.kind;
            out_value_reg <= sat_reg ? VALUE_SAT : quo_reg;
            out_chan_reg  <= ctl_reg.chan;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_chan  = out_chan_reg;

    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE && job_valid) |=> (state_reg == BK_MUL))
        else $error("job popped without starting multiply");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV && step_reg == '0) |=> (state_reg == BK_DONE))
        else $error("divide did not finish after last step");

    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (out_valid_reg && out_kind_reg == $past(ctl_reg.kind)))
        else $error("result not presented after divide");

endmodule

@@ sv/ratiometric_adc_averager.sv @@
// Top level of the ratiometric ADC averager: register port, accumulator, queue, divider.
//
//  port group  dir  transfer when             contents
//  s_*         in   s_tvalid & s_tready       ADC sample and load flag
//  m_*         out  m_tvalid & m_tready       supply or output voltage
//  APB         in   psel&penable&pwrite       four setup registers
//
//  A sample is accepted whenever the job queue has room.
//  Each finished window takes the divider through pop, multiply,
//  saturation check, 16 restoring steps and result load.
//  With windows of one sample the input is paced by the divider once the queue fills.
//  Reset is synchronous, active low; no clearing pass.
//  A stalled result holds the divider; the queue keeps the accumulator going.
module ratiometric_adc_averager
    import rada_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [11:0] sample
    input  logic [0:0]        s_tuser,   // [0] load_on
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [15:0] value, [16] next_channel
    output logic [1:0]        m_tuser,   // [1:0] kind
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 16);
    localparam int SUM_W = ADC_BITS + CNT_W;
    localparam int JOB_W = $bits(job_ctl_t) + SUM_W + 8 + SUM_W;

    logic [3:0] discard_reg;
    logic [5:0] samples_reg;
    logic [7:0] reference_reg;
    logic [7:0] scale_reg;

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    job_ctl_t         f_ctl, b_ctl;
    logic [SUM_W-1:0] f_op_a, b_op_a;
    logic [7:0]       f_op_b, b_op_b;
    logic [SUM_W-1:0] f_den, b_den;
    logic [JOB_W-1:0] q_rdata;

    logic [KIND_W-1:0]  out_kind;
    logic [VALUE_W-1:0] out_value;
    logic               out_chan;

    assign pready   = 1'b1;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            discard_reg   <= DISCARD_RST;
            samples_reg   <= SAMPLES_RST;
            reference_reg <= REFERENCE_RST;
            scale_reg     <= SCALE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_DISCARD:   discard_reg   <= pwdata[3:0];
                REG_SAMPLES:   samples_reg   <= pwdata[5:0];
                REG_REFERENCE: reference_reg <= pwdata[7:0];
                REG_SCALE:     scale_reg     <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DISCARD:   prdata = CFG_DW'(discard_reg);
            REG_SAMPLES:   prdata = CFG_DW'(samples_reg);
            REG_REFERENCE: prdata = CFG_DW'(reference_reg);
            REG_SCALE:     prdata = CFG_DW'(scale_reg);
            default:       prdata = '0;
        endcase
    end

    rada_front #(
        .ADC_BITS    (ADC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .sample        (s_tdata[SAMPLE_W-1:0]),
        .load_on       (s_tuser[0]),
        .discard_cfg   (discard_reg),
        .samples_cfg   (samples_reg),
        .reference_cfg (reference_reg),
        .scale_cfg     (scale_reg),
        .push          (push),
        .job_ctl       (f_ctl),
        .job_op_a      (f_op_a),
        .job_op_b      (f_op_b),
        .job_den       (f_den)
    );

    rada_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   ({f_ctl, f_op_a, f_op_b, f_den}),
        .full    (q_full),
        .pop     (pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    assign {b_ctl, b_op_a, b_op_b, b_den} = q_rdata;

    rada_back #(
        .ADC_BITS    (ADC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!q_empty),
        .job_ctl   (b_ctl),
        .job_op_a  (b_op_a),
        .job_op_b  (b_op_b),
        .job_den   (b_den),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_chan  (out_chan)
    );

    assign m_tdata = {7'd0, out_chan, out_value};
    assign m_tuser = out_kind;

endmodule

@@ verif/ratiometric_adc_averager_tb.sv @@
// Testbench for the ratiometric ADC averager: streams samples, predicts each voltage reading.
`timescale 1ns / 100ps

module ratiometric_adc_averager_tb;
    import rada_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               chan;
    } reading_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [11:0] sample
    logic [0:0]        s_tuser;   // [0] load_on
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // [15:0] value, [16] next_channel
    logic [1:0]        m_tuser;   // [1:0] kind
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    reading_t    pending_readings[$];
    int unsigned mismatches;
    bit          tx_gaps;
    bit          rx_gaps;
    int unsigned rx_wait;
    int unsigned rx_hold;
    logic        load_level;

    logic [3:0]  cfg_skip;
    logic [5:0]  cfg_len;
    logic [7:0]  cfg_ref;
    logic [7:0]  cfg_scale;
    int unsigned win_cnt;
    int unsigned win_acc;
    int unsigned bandgap_acc;
    logic        win_phase;
    logic        load_seen;

    ratiometric_adc_averager uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
        end
    endtask

    task automatic predict_reading(input logic [SAMPLE_W-1:0] smp, input logic ld);
        int unsigned       n;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        reading_t          r;
        n = (cfg_len == 0) ? 1 : ((cfg_len > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : cfg_len);
        if (ld != load_seen) begin
            load_seen = ld;
            win_cnt   = 0;
            win_acc   = 0;
            win_phase = 1'b0;
            return;
        end
        if (win_cnt >= cfg_skip) begin
            win_acc += smp;
        end
        win_cnt++;
        if (win_cnt < cfg_skip + n) begin
            return;
        end
        if (!win_phase) begin
            num         = longint'(cfg_ref) * (64'd1 << ADC_BITS_DEF) * n;
            den         = win_acc;
            bandgap_acc = win_acc;
            r.kind      = load_seen ? KIND_LOADED : KIND_IDLE;
            if (load_seen) begin
                win_phase = 1'b1;
            end
        end else begin
            num       = longint'(win_acc) * cfg_scale;
            den       = bandgap_acc;
            r.kind    = KIND_OUTPUT;
            win_phase = 1'b0;
        end
        if (den == 0) begin
            q = VALUE_SAT;
        end else begin
            q = num / den;
            if (q > VALUE_SAT) begin
                q = VALUE_SAT;
            end
        end
        r.value = q[VALUE_W-1:0];
        r.chan  = win_phase;
        win_cnt = 0;
        win_acc = 0;
        pending_readings.push_back(r);
    endtask

    // receiver: hold off when asked, else stall after transfers when gaps are on
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        reading_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("unexpected reading", 0, m_tdata);
                end else begin
                    exp_r = pending_readings.pop_front();
                    if (m_tuser !== exp_r.kind) begin
                        report_mismatch("kind", exp_r.kind, m_tuser);
                    end
                    if (m_tdata[15:0] !== exp_r.value) begin
                        report_mismatch("value", exp_r.value, m_tdata[15:0]);
                    end
                    if (m_tdata[16] !== exp_r.chan) begin
                        report_mismatch("next_channel", exp_r.chan, m_tdata[16]);
                    end
                end
                rx_wait = rx_gaps ? $urandom_range(0, 9) : 0;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic ld);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(smp);
        s_tuser  <= ld;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_reading(smp, ld);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (64) @(negedge aclk);
    endtask

    function automatic logic [CFG_DW-1:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_DISCARD:   return CFG_DW'(cfg_skip);
            REG_SAMPLES:   return CFG_DW'(cfg_len);
            REG_REFERENCE: return CFG_DW'(cfg_ref);
            default:       return CFG_DW'(cfg_scale);
        endcase
    endfunction

    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [CFG_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (wr) begin
            case (idx)
                REG_DISCARD:   cfg_skip  = data[3:0];
                REG_SAMPLES:   cfg_len   = data[5:0];
                REG_REFERENCE: cfg_ref   = data[7:0];
                REG_SCALE:     cfg_scale = data[7:0];
                default: ;
            endcase
        end else if (prdata !== reg_value(idx)) begin
            report_mismatch("register readback", reg_value(idx), prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_setup(input int unsigned skip, input int unsigned len,
                                 input int unsigned refv, input int unsigned scale);
        settle();
        apb_access(REG_DISCARD, 1'b1, skip);
        apb_access(REG_SAMPLES, 1'b1, len);
        apb_access(REG_REFERENCE, 1'b1, refv);
        apb_access(REG_SCALE, 1'b1, scale);
        apb_access(REG_DISCARD, 1'b0, 0);
        apb_access(REG_SAMPLES, 1'b0, 0);
        apb_access(REG_REFERENCE, 1'b0, 0);
        apb_access(REG_SCALE, 1'b0, 0);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 25) return SAMPLE_W'($urandom_range(1, 15));
        if (pick < 45) return SAMPLE_W'($urandom_range(1100, 1900));
        return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    task automatic stream_random(input int items, input int flip_pct);
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < flip_pct) begin
                load_level = ~load_level;
            end
            send_sample(draw_sample(), load_level);
        end
    endtask

    task automatic test_register_defaults();
        apb_access(REG_DISCARD, 1'b0, 0);
        apb_access(REG_SAMPLES, 1'b0, 0);
        apb_access(REG_REFERENCE, 1'b0, 0);
        apb_access(REG_SCALE, 1'b0, 0);
    endtask

    task automatic test_idle_supply();
        program_setup(0, 1, 255, 255);
        load_level = 1'b0;
        send_sample(12'hFFF, load_level);
        send_sample(12'h000, load_level);
        send_sample(12'h001, load_level);
    endtask

    task automatic test_loaded_cycle();
        load_level = 1'b1;
        send_sample(12'h5A5, load_level);
        send_sample(12'hFFF, load_level);
        send_sample(12'hFFF, load_level);
    endtask

    task automatic test_zero_bandgap();
        send_sample(12'h000, load_level);
        send_sample(12'd100, load_level);
    endtask

    task automatic test_load_change();
        program_setup(2, 3, 200, 100);
        send_sample(12'd1500, load_level);
        send_sample(12'd1600, load_level);
        load_level = 1'b0;
        send_sample(12'd1700, load_level);
        for (int i = 0; i < 5; i++) begin
            send_sample(12'd1200 + 12'(i), load_level);
        end
    endtask

    task automatic test_sample_count_clamp();
        program_setup(0, 0, 100, 50);
        send_sample(12'd800, load_level);
        send_sample(12'd3000, load_level);
    endtask

    task automatic test_backpressure();
        program_setup(0, 1, 120, 144);
        tx_gaps    = 1'b0;
        rx_gaps    = 1'b0;
        load_level = 1'b1;
        @(negedge aclk);
        rx_hold = 300;
        for (int i = 0; i < 60; i++) begin
            send_sample(SAMPLE_W'($urandom_range(0, 4095)), load_level);
        end
        settle();
        for (int i = 0; i < 20; i++) begin
            send_sample(draw_sample(), load_level);
        end
    endtask

    task automatic test_random_setups();
        program_setup(4, 18, 120, 144);
        stream_random(120, 1);
        program_setup(15, 32, 0, 0);
        load_level = 1'b1;
        stream_random(100, 0);
        program_setup(0, 63, 255, 255);
        stream_random(70, 0);
        for (int p = 0; p < 14; p++) begin
            program_setup($urandom_range(0, 3),
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                          $urandom_range(0, 255), $urandom_range(0, 255));
            stream_random(50, 4);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        tx_gaps     = 1'b0;
        rx_gaps     = 1'b0;
        rx_wait     = 0;
        rx_hold     = 0;
        load_level  = 1'b0;
        cfg_skip    = DISCARD_RST;
        cfg_len     = SAMPLES_RST;
        cfg_ref     = REFERENCE_RST;
        cfg_scale   = SCALE_RST;
        win_cnt     = 0;
        win_acc     = 0;
        bandgap_acc = 0;
        win_phase   = 1'b0;
        load_seen   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_defaults();
        test_idle_supply();
        test_loaded_cycle();
        test_zero_bandgap();
        test_load_change();
        test_sample_count_clamp();
        test_backpressure();
        test_random_setups();

        settle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/rada_pkg.sv
sv/rada_fifo.sv
sv/rada_front.sv
sv/rada_back.sv
sv/ratiometric_adc_averager.sv
verif/ratiometric_adc_averager_tb.sv
